@@ rtl/mcwt_pkg.sv @@
package mcwt_pkg;

  // default sizing
  localparam int SLOTS_DEF      = 8;
  localparam int COUNT_BITS_DEF = 16;

  // fixed field widths
  localparam int MODE_W = 3;
  localparam int ID_W   = 4;
  localparam int TMO_W  = 16;

  // operation codes
  typedef enum logic [MODE_W-1:0] {
    MODE_REG   = 3'd0,
    MODE_KICK  = 3'd1,
    MODE_START = 3'd2,
    MODE_STOP  = 3'd3,
    MODE_TICK  = 3'd4
  } mode_t;

  // result fields of one word
  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] assigned;
    logic            reboot;
    logic [ID_W-1:0] expired;
  } res_t;

  // token that walks the chain of slot cells
  typedef struct packed {
    logic            valid;
    mode_t           mode;
    logic [ID_W-1:0] id;
    logic            done;
    res_t            res;
  } tok_t;

endpackage

@@ rtl/multi_client_watchdog_table.sv @@
// Table of SLOTS software watchdog slots built as a row of slot cells. Each
// accepted word (register, kick, start, stop or tick) becomes a token that
// moves one cell per clock from slot 0 upward; every cell applies the
// operation to its own slot, so register takes the lowest free slot and tick
// stops at the first expired armed slot. A word's result passes from the last
// cell to the output register; while results are taken at once, the next word
// is taken in the cycle after the token leaves the row, so no new word is
// taken while a token is still in the row. Results go to
// an output register with a one-entry holding stage behind it; a stalled
// result waits there and holds off the next word until it moves into the
// output register. Claimed slots stay claimed until reset; timeouts wider
// than COUNT_BITS saturate.
module multi_client_watchdog_table #(
  parameter int SLOTS      = mcwt_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = mcwt_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mcwt_pkg::MODE_W-1:0]   mode,
  input  logic [mcwt_pkg::ID_W-1:0]     client_id,
  input  logic [mcwt_pkg::TMO_W-1:0]    timeout_secs,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [mcwt_pkg::ID_W-1:0]     assigned_id,
  output logic                          reboot,
  output logic [mcwt_pkg::ID_W-1:0]     expired_id
);

  localparam logic [31:0] COUNT_MAX =
    (COUNT_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNT_BITS) - 64'd1);

  mcwt_pkg::tok_t        tok [SLOTS+1];
  logic [COUNT_BITS-1:0] cnt [SLOTS+1];

  logic                  busy;
  logic                  accept;
  logic                  out_free;
  logic                  hold_valid;
  mcwt_pkg::res_t        hold;
  mcwt_pkg::res_t        res;
  logic [31:0]           tmo_wide;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign tmo_wide = 32'(timeout_secs);

  // token entering the row
  always_comb begin
    tok[0].valid = accept;
    tok[0].mode  = mcwt_pkg::mode_t'(mode);
    tok[0].id    = client_id;
    tok[0].done  = 1'b0;
    tok[0].res   = '0;
    cnt[0]       = COUNT_BITS'((tmo_wide > COUNT_MAX) ? COUNT_MAX : tmo_wide);
  end

  // row of slot cells
  for (genvar s = 0; s < SLOTS; s++) begin : g_cell
    mcwt_cell #(
      .SLOT       (s),
      .SLOTS      (SLOTS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok[s]),
      .cnt_in  (cnt[s]),
      .tok_out (tok[s+1]),
      .cnt_out (cnt[s+1])
    );
  end

  // busy, output and holding stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end
      if (tok[SLOTS].valid) begin
        if (out_free) begin
          out_valid <= 1'b1;
          busy      <= 1'b0;
        end else begin
          hold_valid <= 1'b1;
        end
      end else if (hold_valid && out_free) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
        busy       <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (tok[SLOTS].valid) begin
      if (out_free) begin
        res <= tok[SLOTS].res;
      end else begin
        hold <= tok[SLOTS].res;
      end
    end else if (hold_valid && out_free) begin
      res <= hold;
    end
  end

  assign ok          = res.ok;
  assign assigned_id = res.assigned;
  assign reboot      = res.reboot;
  assign expired_id  = res.expired;

endmodule

@@ rtl/mcwt_cell.sv @@
module mcwt_cell #(
  parameter int SLOT       = 0,
  parameter int SLOTS      = mcwt_pkg::SLOTS_DEF,
  parameter int COUNT_BITS = mcwt_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mcwt_pkg::tok_t        tok_in,
  input  logic [COUNT_BITS-1:0] cnt_in,
  output mcwt_pkg::tok_t        tok_out,
  output logic [COUNT_BITS-1:0] cnt_out
);

  localparam int IDX_W = $clog2(SLOTS + 2);
  localparam logic [IDX_W-1:0] MY_ID = IDX_W'(SLOT + 1);
  localparam logic [mcwt_pkg::ID_W-1:0] MY_ID_OUT = mcwt_pkg::ID_W'(SLOT + 1);

  // slot state
  logic                  used;
  logic                  armed;
  logic [COUNT_BITS-1:0] timeout;
  logic [COUNT_BITS-1:0] remaining;

  logic                  used_next;
  logic                  armed_next;
  logic [COUNT_BITS-1:0] timeout_next;
  logic [COUNT_BITS-1:0] remaining_next;
  mcwt_pkg::tok_t        tok_next;
  logic                  id_hit;

  // id match against this slot, zero never matches
  always_comb begin
    if (IDX_W >= mcwt_pkg::ID_W) begin
      id_hit = (IDX_W'(tok_in.id) == MY_ID) && used;
    end else begin
      id_hit = (tok_in.id == mcwt_pkg::ID_W'(MY_ID)) && used;
    end
  end

  // operation on this slot as the token passes
  always_comb begin
    used_next      = used;
    armed_next     = armed;
    timeout_next   = timeout;
    remaining_next = remaining;
    tok_next       = tok_in;
    if (tok_in.valid) begin
      case (tok_in.mode)
        mcwt_pkg::MODE_REG: begin
          if (!tok_in.done && !used) begin
            used_next             = 1'b1;
            timeout_next          = cnt_in;
            remaining_next        = cnt_in;
            tok_next.done         = 1'b1;
            tok_next.res.ok       = 1'b1;
            tok_next.res.assigned = MY_ID_OUT;
          end
        end
        mcwt_pkg::MODE_KICK: begin
          if (id_hit) begin
            remaining_next  = timeout;
            tok_next.res.ok = 1'b1;
          end
        end
        mcwt_pkg::MODE_START: begin
          if (id_hit) begin
            remaining_next  = timeout;
            armed_next      = 1'b1;
            tok_next.res.ok = 1'b1;
          end
        end
        mcwt_pkg::MODE_STOP: begin
          if (id_hit) begin
            armed_next      = 1'b0;
            tok_next.res.ok = 1'b1;
          end
        end
        mcwt_pkg::MODE_TICK: begin
          if (!tok_in.done && used && armed) begin
            if (remaining <= COUNT_BITS'(1)) begin
              tok_next.done        = 1'b1;
              tok_next.res.reboot  = 1'b1;
              tok_next.res.expired = MY_ID_OUT;
            end else begin
              remaining_next = remaining - COUNT_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control state, counts and token hand-off
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      armed         <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      used          <= used_next;
      armed         <= armed_next;
      tok_out.valid <= tok_next.valid;
    end
    timeout      <= timeout_next;
    remaining    <= remaining_next;
    tok_out.mode <= tok_next.mode;
    tok_out.id   <= tok_next.id;
    tok_out.done <= tok_next.done;
    tok_out.res  <= tok_next.res;
    cnt_out      <= cnt_in;
  end

endmodule
